// ===== sv/ecf_pkg.sv =====
// ----------------------------------------------------------------------------
// Election candidate package
// Shared types, command and opcode codes, and register reset values for the
// candidate-side leader election block.
// ----------------------------------------------------------------------------
package ecf_pkg;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_STOP    = 2'd1,
        ACT_MESSAGE = 2'd2,
        ACT_EXPIRE  = 2'd3
    } action_t;

    localparam logic [2:0] OP_NOOP       = 3'd0;
    localparam logic [2:0] OP_VOTE       = 3'd1;
    localparam logic [2:0] OP_NOMINATION = 3'd2;
    localparam logic [2:0] OP_LEAD       = 3'd3;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_NOMINATE = 3'd1;
    localparam logic [2:0] CMD_LEADER   = 3'd2;
    localparam logic [2:0] CMD_FOLLOW   = 3'd3;
    localparam logic [2:0] CMD_ACCEPT   = 3'd4;
    localparam logic [2:0] CMD_GIVEUP   = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN  = 3'd6;

    localparam logic [1:0] CFG_PEER_COUNT  = 2'd0;
    localparam logic [1:0] CFG_MIN_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd3;

    localparam logic [7:0]  PEER_COUNT_RESET  = 8'd2;
    localparam logic [31:0] MIN_TIMEOUT_RESET = 32'd150000000;
    localparam logic [31:0] MAX_TIMEOUT_RESET = 32'd300000000;
    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd100;

    localparam logic [8:0] VOTE_MAX  = 9'd511;
    localparam logic [7:0] RETRY_MAX = 8'd255;

    typedef struct packed {
        action_t     action;
        logic [2:0]  opcode;
        logic [31:0] msg_term;
        logic [31:0] msg_extra;
        logic [7:0]  remote_node;
        logic [7:0]  remote_cluster;
    } event_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] out_term;
        logic [31:0] out_extra;
        logic [7:0]  out_node;
        logic [7:0]  out_cluster;
        logic        arm_timer;
        logic        cancel_timer;
        logic [39:0] timer_low;
        logic [39:0] timer_high;
        logic [8:0]  votes_now;
    } result_t;

    typedef struct packed {
        logic [31:0] current_term;
        logic [8:0]  vote_count;
        logic [7:0]  retry_count;
        logic        active;
    } cand_state_t;

    typedef struct packed {
        logic [7:0]  peer_count;
        logic [31:0] min_timeout;
        logic [31:0] max_timeout;
        logic [7:0]  retry_limit;
    } cfg_t;

endpackage

// ===== sv/ecf_cfg.sv =====
// ----------------------------------------------------------------------------
// Election candidate configuration registers
// Holds peer count, base timeout bounds and retry limit, written by index.
// ----------------------------------------------------------------------------
module ecf_cfg
    import ecf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peer_count  <= PEER_COUNT_RESET;
            cfg_reg.min_timeout <= MIN_TIMEOUT_RESET;
            cfg_reg.max_timeout <= MAX_TIMEOUT_RESET;
            cfg_reg.retry_limit <= RETRY_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PEER_COUNT:  cfg_reg.peer_count  <= cfg_data[7:0];
                CFG_MIN_TIMEOUT: cfg_reg.min_timeout <= cfg_data;
                CFG_MAX_TIMEOUT: cfg_reg.max_timeout <= cfg_data;
                CFG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_data[7:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/ecf_step.sv =====
// ----------------------------------------------------------------------------
// Election candidate step logic
// Computes the result and the next candidate state for one event.
// ----------------------------------------------------------------------------
module ecf_step
    import ecf_pkg::*;
(
    input  event_t      ev,
    input  cand_state_t st,
    input  cfg_t        cfg,
    output result_t     res,
    output cand_state_t st_next
);

    logic [7:0]  retry_inc;
    logic [8:0]  vote_inc;
    logic [31:0] term_inc;
    logic [7:0]  scale;
    logic [39:0] bound_low;
    logic [39:0] bound_high;
    logic        majority;

    assign retry_inc = (st.retry_count < RETRY_MAX) ? st.retry_count + 8'd1 : st.retry_count;
    assign vote_inc  = (st.vote_count < VOTE_MAX) ? st.vote_count + 9'd1 : st.vote_count;
    assign term_inc  = st.current_term + 32'd1;
    assign majority  = {1'b0, vote_inc, 1'b0} >= {3'b000, cfg.peer_count} + 11'd1;

    // Bounds are scaled by the retry count after an expiry, else taken as is.
    assign scale      = (ev.action == ACT_EXPIRE) ? retry_inc : 8'd1;
    assign bound_low  = 40'(scale) * 40'(cfg.min_timeout);
    assign bound_high = 40'(scale) * 40'(cfg.max_timeout);

    always_comb
    begin
        res     = '0;
        st_next = st;
        unique case (ev.action)
            ACT_START:
            begin
                st_next.active       = 1'b1;
                st_next.retry_count  = 8'd0;
                st_next.current_term = term_inc;
                st_next.vote_count   = 9'd1;
                res.command          = CMD_NOMINATE;
                res.out_term         = term_inc;
                res.arm_timer        = 1'b1;
                res.timer_low        = bound_low;
                res.timer_high       = bound_high;
            end
            ACT_STOP:
            begin
                if (st.active)
                begin
                    st_next.active   = 1'b0;
                    res.cancel_timer = 1'b1;
                end
            end
            ACT_EXPIRE:
            begin
                if (st.active)
                begin
                    st_next.retry_count = retry_inc;
                    if (retry_inc >= cfg.retry_limit)
                    begin
                        res.command    = CMD_GIVEUP;
                        st_next.active = 1'b0;
                    end
                    else
                    begin
                        st_next.current_term = term_inc;
                        st_next.vote_count   = 9'd1;
                        res.command          = CMD_NOMINATE;
                        res.out_term         = term_inc;
                        res.arm_timer        = 1'b1;
                        res.timer_low        = bound_low;
                        res.timer_high       = bound_high;
                    end
                end
            end
            ACT_MESSAGE:
            begin
                if (st.active)
                begin
                    unique case (ev.opcode)
                        OP_NOOP:
                        begin
                            res.command = CMD_NONE;
                        end
                        OP_VOTE:
                        begin
                            st_next.vote_count = vote_inc;
                            if (majority)
                            begin
                                res.command        = CMD_LEADER;
                                res.cancel_timer   = 1'b1;
                                st_next.active     = 1'b0;
                            end
                            else
                            begin
                                st_next.retry_count = 8'd0;
                                res.arm_timer       = 1'b1;
                                res.timer_low       = bound_low;
                                res.timer_high      = bound_high;
                            end
                        end
                        OP_NOMINATION:
                        begin
                            if (ev.msg_term > st.current_term)
                            begin
                                res.command      = CMD_FOLLOW;
                                res.cancel_timer = 1'b1;
                                st_next.active   = 1'b0;
                                res.out_term     = ev.msg_term;
                                res.out_extra    = ev.msg_extra;
                                res.out_node     = ev.remote_node;
                                res.out_cluster  = ev.remote_cluster;
                            end
                        end
                        OP_LEAD:
                        begin
                            if (ev.msg_term >= st.current_term)
                            begin
                                res.command      = CMD_ACCEPT;
                                res.cancel_timer = 1'b1;
                                st_next.active   = 1'b0;
                                res.out_term     = ev.msg_term;
                                res.out_node     = ev.remote_node;
                                res.out_cluster  = ev.remote_cluster;
                            end
                        end
                        default:
                        begin
                            res.command = CMD_UNKNOWN;
                        end
                    endcase
                end
            end
            default:
            begin
                res.command = CMD_NONE;
            end
        endcase
        res.votes_now = st_next.vote_count;
    end

endmodule

// ===== sv/election_candidate_fsm.sv =====
// ----------------------------------------------------------------------------
// Election candidate FSM
// Candidate side of a leader election: one result beat for each event beat.
// An accepted event beat is held in one input register, then passes the
// step logic and its two 8x32 multipliers into the result register.
// One event beat is accepted every cycle while results drain.
// Reset clears term, vote and retry counts and the active flag, and loads the
// configuration registers with their default values.
// ----------------------------------------------------------------------------
module election_candidate_fsm
    import ecf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        event_valid,
    output logic        event_stall,
    input  logic [1:0]  action,
    input  logic [2:0]  opcode,
    input  logic [31:0] msg_term,
    input  logic [31:0] msg_extra,
    input  logic [7:0]  remote_node,
    input  logic [7:0]  remote_cluster,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  command,
    output logic [31:0] out_term,
    output logic [31:0] out_extra,
    output logic [7:0]  out_node,
    output logic [7:0]  out_cluster,
    output logic        arm_timer,
    output logic        cancel_timer,
    output logic [39:0] timer_low,
    output logic [39:0] timer_high,
    output logic [8:0]  votes_now
);

    cfg_t        cfg;
    event_t      ev_reg;
    logic        ev_valid_reg;
    result_t     res_reg;
    logic        res_valid_reg;
    cand_state_t st_reg;
    cand_state_t st_next;
    result_t     res_next;
    logic        out_free;
    logic        advance;
    logic        accept;

    ecf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ecf_step u_step (
        .ev      (ev_reg),
        .st      (st_reg),
        .cfg     (cfg),
        .res     (res_next),
        .st_next (st_next)
    );

    assign out_free    = !res_valid_reg || !result_stall;
    assign advance     = ev_valid_reg && out_free;
    assign event_stall = ev_valid_reg && !out_free;
    assign accept      = event_valid && !event_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                ev_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                ev_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                res_valid_reg <= ev_valid_reg;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg.action         <= action_t'(action);
            ev_reg.opcode         <= opcode;
            ev_reg.msg_term       <= msg_term;
            ev_reg.msg_extra      <= msg_extra;
            ev_reg.remote_node    <= remote_node;
            ev_reg.remote_cluster <= remote_cluster;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign command      = res_reg.command;
    assign out_term     = res_reg.out_term;
    assign out_extra    = res_reg.out_extra;
    assign out_node     = res_reg.out_node;
    assign out_cluster  = res_reg.out_cluster;
    assign arm_timer    = res_reg.arm_timer;
    assign cancel_timer = res_reg.cancel_timer;
    assign timer_low    = res_reg.timer_low;
    assign timer_high   = res_reg.timer_high;
    assign votes_now    = res_reg.votes_now;

endmodule

// ===== sim/ecf_checker.sv =====
// ----------------------------------------------------------------------------
// Election candidate checker
// Watches the configuration port and both beat channels of the candidate
// election block. It keeps its own copy of the configuration and of the
// candidate state, predicts the result beat of every accepted event beat,
// and compares each accepted result beat field by field with the oldest
// prediction. The failure count and the number of outstanding predictions
// go to the testbench top.
// ----------------------------------------------------------------------------
module ecf_checker
    import ecf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        event_valid,
    input  logic        event_stall,
    input  logic [1:0]  action,
    input  logic [2:0]  opcode,
    input  logic [31:0] msg_term,
    input  logic [31:0] msg_extra,
    input  logic [7:0]  remote_node,
    input  logic [7:0]  remote_cluster,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [2:0]  command,
    input  logic [31:0] out_term,
    input  logic [31:0] out_extra,
    input  logic [7:0]  out_node,
    input  logic [7:0]  out_cluster,
    input  logic        arm_timer,
    input  logic        cancel_timer,
    input  logic [39:0] timer_low,
    input  logic [39:0] timer_high,
    input  logic [8:0]  votes_now,
    output int          fail_count,
    output int          pending,
    output logic [31:0] model_term,
    output logic        model_active
);

    cfg_t        cfg;
    cand_state_t cand;
    result_t     expected_results[$];

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ecf_checker: %s", msg);
    endtask

    task automatic check_field(input string fname, input logic [39:0] want,
                               input logic [39:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %0h, actual %0h",
                                   fname, want, got));
    endtask

    function automatic result_t nominate(input logic [7:0] scale);
        result_t r;
        r = '0;
        cand.current_term = cand.current_term + 32'd1;
        cand.vote_count = 9'd1;
        r.command = CMD_NOMINATE;
        r.out_term = cand.current_term;
        r.arm_timer = 1'b1;
        r.timer_low = {32'd0, scale} * {8'd0, cfg.min_timeout};
        r.timer_high = {32'd0, scale} * {8'd0, cfg.max_timeout};
        return r;
    endfunction

    function automatic result_t resign(input logic [2:0] cmd);
        result_t r;
        r = '0;
        r.command = cmd;
        r.cancel_timer = 1'b1;
        cand.active = 1'b0;
        return r;
    endfunction

    function automatic result_t candidate_step(input event_t ev);
        result_t r;
        r = '0;
        case (ev.action)
            ACT_START:
            begin
                cand.active = 1'b1;
                cand.retry_count = '0;
                r = nominate(8'd1);
            end
            ACT_STOP:
            begin
                if (cand.active)
                begin
                    cand.active = 1'b0;
                    r.cancel_timer = 1'b1;
                end
            end
            ACT_EXPIRE:
            begin
                if (cand.active)
                begin
                    if (cand.retry_count != RETRY_MAX)
                        cand.retry_count = cand.retry_count + 8'd1;
                    if (cand.retry_count >= cfg.retry_limit)
                    begin
                        r.command = CMD_GIVEUP;
                        cand.active = 1'b0;
                    end
                    else
                    begin
                        r = nominate(cand.retry_count);
                    end
                end
            end
            default:
            begin
                if (cand.active)
                begin
                    case (ev.opcode)
                        OP_NOOP:
                        begin
                        end
                        OP_VOTE:
                        begin
                            if (cand.vote_count != VOTE_MAX)
                                cand.vote_count = cand.vote_count + 9'd1;
                            if ({cand.vote_count, 1'b0} >= {2'b00, cfg.peer_count} + 10'd1)
                            begin
                                r = resign(CMD_LEADER);
                            end
                            else
                            begin
                                cand.retry_count = '0;
                                r.arm_timer = 1'b1;
                                r.timer_low = {8'd0, cfg.min_timeout};
                                r.timer_high = {8'd0, cfg.max_timeout};
                            end
                        end
                        OP_NOMINATION:
                        begin
                            if (ev.msg_term > cand.current_term)
                            begin
                                r = resign(CMD_FOLLOW);
                                r.out_term = ev.msg_term;
                                r.out_extra = ev.msg_extra;
                                r.out_node = ev.remote_node;
                                r.out_cluster = ev.remote_cluster;
                            end
                        end
                        OP_LEAD:
                        begin
                            if (ev.msg_term >= cand.current_term)
                            begin
                                r = resign(CMD_ACCEPT);
                                r.out_term = ev.msg_term;
                                r.out_node = ev.remote_node;
                                r.out_cluster = ev.remote_cluster;
                            end
                        end
                        default:
                        begin
                            r.command = CMD_UNKNOWN;
                        end
                    endcase
                end
            end
        endcase
        r.votes_now = cand.vote_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        event_t  ev;
        result_t want;
        if (!rst_n)
        begin
            cfg.peer_count = PEER_COUNT_RESET;
            cfg.min_timeout = MIN_TIMEOUT_RESET;
            cfg.max_timeout = MAX_TIMEOUT_RESET;
            cfg.retry_limit = RETRY_LIMIT_RESET;
            cand = '0;
            expected_results.delete();
            pending <= 0;
            model_term <= '0;
            model_active <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PEER_COUNT:  cfg.peer_count = cfg_data[7:0];
                    CFG_MIN_TIMEOUT: cfg.min_timeout = cfg_data;
                    CFG_MAX_TIMEOUT: cfg.max_timeout = cfg_data;
                    default:         cfg.retry_limit = cfg_data[7:0];
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("result beat with command %0h arrived unexpectedly",
                                           command));
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("command", 40'(want.command), 40'(command));
                    check_field("out_term", 40'(want.out_term), 40'(out_term));
                    check_field("out_extra", 40'(want.out_extra), 40'(out_extra));
                    check_field("out_node", 40'(want.out_node), 40'(out_node));
                    check_field("out_cluster", 40'(want.out_cluster), 40'(out_cluster));
                    check_field("arm_timer", 40'(want.arm_timer), 40'(arm_timer));
                    check_field("cancel_timer", 40'(want.cancel_timer), 40'(cancel_timer));
                    check_field("timer_low", want.timer_low, timer_low);
                    check_field("timer_high", want.timer_high, timer_high);
                    check_field("votes_now", 40'(want.votes_now), 40'(votes_now));
                end
            end
            if (event_valid && !event_stall)
            begin
                ev.action = action_t'(action);
                ev.opcode = opcode;
                ev.msg_term = msg_term;
                ev.msg_extra = msg_extra;
                ev.remote_node = remote_node;
                ev.remote_cluster = remote_cluster;
                expected_results.push_back(candidate_step(ev));
            end
            pending <= expected_results.size();
            model_term <= cand.current_term;
            model_active <= cand.active;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Election candidate testbench
// Drives event beats into the candidate election block under a series of
// register settings: a directed opening that walks through every action,
// opcode and corner case, then random sequences that mostly follow a real
// election, with random idling on both channels, one long result hold-off
// and a quiet final phase. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import ecf_pkg::*;

    localparam int         CYCLE_LIMIT    = 500000;
    localparam int         PHASES         = 8;
    localparam int         PHASE_ITEMS    = 70;
    localparam int         RETRY_RUN      = 290;
    localparam int         LONG_HOLD      = 80;
    localparam logic [2:0] OP_UNKNOWN_LO  = 3'd4;
    localparam logic [2:0] OP_UNKNOWN_HI  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        event_valid;
    logic        event_stall;
    logic [1:0]  action;
    logic [2:0]  opcode;
    logic [31:0] msg_term;
    logic [31:0] msg_extra;
    logic [7:0]  remote_node;
    logic [7:0]  remote_cluster;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  command;
    logic [31:0] out_term;
    logic [31:0] out_extra;
    logic [7:0]  out_node;
    logic [7:0]  out_cluster;
    logic        arm_timer;
    logic        cancel_timer;
    logic [39:0] timer_low;
    logic [39:0] timer_high;
    logic [8:0]  votes_now;

    int          fail_count;
    int          pending;
    logic [31:0] model_term;
    logic        model_active;
    int          cycle_count = 0;
    int          hold_requests = 0;
    bit          quiet = 1'b0;

    election_candidate_fsm i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .event_valid    (event_valid),
        .event_stall    (event_stall),
        .action         (action),
        .opcode         (opcode),
        .msg_term       (msg_term),
        .msg_extra      (msg_extra),
        .remote_node    (remote_node),
        .remote_cluster (remote_cluster),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .command        (command),
        .out_term       (out_term),
        .out_extra      (out_extra),
        .out_node       (out_node),
        .out_cluster    (out_cluster),
        .arm_timer      (arm_timer),
        .cancel_timer   (cancel_timer),
        .timer_low      (timer_low),
        .timer_high     (timer_high),
        .votes_now      (votes_now)
    );

    ecf_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .event_valid    (event_valid),
        .event_stall    (event_stall),
        .action         (action),
        .opcode         (opcode),
        .msg_term       (msg_term),
        .msg_extra      (msg_extra),
        .remote_node    (remote_node),
        .remote_cluster (remote_cluster),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .command        (command),
        .out_term       (out_term),
        .out_extra      (out_extra),
        .out_node       (out_node),
        .out_cluster    (out_cluster),
        .arm_timer      (arm_timer),
        .cancel_timer   (cancel_timer),
        .timer_low      (timer_low),
        .timer_high     (timer_high),
        .votes_now      (votes_now),
        .fail_count     (fail_count),
        .pending        (pending),
        .model_term     (model_term),
        .model_active   (model_active)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // The result side stalls in random bursts and honors long hold-off requests.
    initial
    begin : result_side
        int holds_served;
        holds_served = 0;
        result_stall <= 1'b0;
        forever
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic event_t mk_event(input action_t act, input logic [2:0] op,
                                        input logic [31:0] term, input logic [31:0] extra,
                                        input logic [7:0] node, input logic [7:0] cluster);
        event_t ev;
        ev.action = act;
        ev.opcode = op;
        ev.msg_term = term;
        ev.msg_extra = extra;
        ev.remote_node = node;
        ev.remote_cluster = cluster;
        return ev;
    endfunction

    function automatic event_t make_event(input logic [31:0] near_term, input logic near_active,
                                          input bit retry_run);
        event_t      ev;
        int unsigned pick;
        ev = mk_event(ACT_MESSAGE, OP_NOOP, 32'd0, $urandom, 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (retry_run)
        begin
            if (pick < 95)
                ev.action = ACT_EXPIRE;
            else
                ev.opcode = (pick < 97) ? OP_NOOP : 3'($urandom_range(OP_UNKNOWN_LO,
                                                                      OP_UNKNOWN_HI));
        end
        else if (pick < 10)
        begin
            ev.action = action_t'($urandom_range(0, 3));
            ev.opcode = 3'($urandom);
            ev.msg_term = $urandom;
        end
        else
        begin
            if (!near_active && $urandom_range(0, 9) < 7)
                ev.action = ACT_START;
            else if (pick < 16)
                ev.action = ACT_START;
            else if (pick < 21)
                ev.action = ACT_STOP;
            else if (pick < 40)
                ev.action = ACT_EXPIRE;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    ev.opcode = OP_VOTE;
                else if (pick < 66)
                    ev.opcode = OP_NOMINATION;
                else if (pick < 82)
                    ev.opcode = OP_LEAD;
                else if (pick < 90)
                    ev.opcode = OP_NOOP;
                else
                    ev.opcode = 3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
            end
            if ($urandom_range(0, 6) == 0)
                ev.msg_term = $urandom;
            else
                ev.msg_term = near_term + 32'($urandom_range(0, 4)) - 32'd2;
        end
        return ev;
    endfunction

    function automatic cfg_t phase_setting(input int phase);
        cfg_t setting;
        setting.min_timeout = $urandom;
        setting.max_timeout = $urandom;
        case (phase)
            0:
            begin
                setting.peer_count = 8'd0;
                setting.min_timeout = 32'd0;
                setting.max_timeout = 32'd0;
                setting.retry_limit = 8'd1;
            end
            1:
            begin
                setting.peer_count = 8'hFF;
                setting.min_timeout = 32'hFFFF_FFFF;
                setting.max_timeout = 32'hFFFF_FFFF;
                setting.retry_limit = 8'hFF;
            end
            2:
            begin
                setting.peer_count = 8'd3;
                setting.retry_limit = 8'd0;
            end
            default:
            begin
                setting.peer_count = 8'($urandom_range(0, 6));
                setting.retry_limit = 8'($urandom_range(1, 12));
            end
        endcase
        return setting;
    endfunction

    task automatic load_config(input cfg_t setting);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PEER_COUNT;
        cfg_data <= {24'd0, setting.peer_count};
        @(posedge clk);
        cfg_index <= CFG_MIN_TIMEOUT;
        cfg_data <= setting.min_timeout;
        @(posedge clk);
        cfg_index <= CFG_MAX_TIMEOUT;
        cfg_data <= setting.max_timeout;
        @(posedge clk);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data <= {24'd0, setting.retry_limit};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer(input event_t ev);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            event_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        event_valid <= 1'b1;
        action <= ev.action;
        opcode <= ev.opcode;
        msg_term <= ev.msg_term;
        msg_extra <= ev.msg_extra;
        remote_node <= ev.remote_node;
        remote_cluster <= ev.remote_cluster;
        do
            @(posedge clk);
        while (event_stall);
    endtask

    task automatic drain();
        event_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        cfg_t setting;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_PEER_COUNT;
        cfg_data <= '0;
        event_valid <= 1'b0;
        action <= ACT_START;
        opcode <= OP_NOOP;
        msg_term <= '0;
        msg_extra <= '0;
        remote_node <= '0;
        remote_cluster <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: idle events, restarts, ignored messages, each way out but give-up.
        offer(mk_event(ACT_STOP, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_MESSAGE, OP_VOTE, '0, '0, '0, '0));
        offer(mk_event(ACT_EXPIRE, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_MESSAGE, OP_UNKNOWN_HI, '1, '1, '1, '1));
        offer(mk_event(ACT_START, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_START, OP_VOTE, '1, '1, '1, '1));
        offer(mk_event(ACT_MESSAGE, OP_NOOP, '1, '1, '1, '1));
        offer(mk_event(ACT_MESSAGE, OP_UNKNOWN_HI, '1, '1, '1, '1));
        offer(mk_event(ACT_MESSAGE, OP_UNKNOWN_LO, '0, '0, '0, '0));
        offer(mk_event(ACT_MESSAGE, OP_NOMINATION, 32'd0, '1, '1, '1));
        offer(mk_event(ACT_MESSAGE, OP_NOMINATION, 32'd2, '1, '1, '1));
        offer(mk_event(ACT_MESSAGE, OP_LEAD, 32'd1, '1, '1, '1));
        offer(mk_event(ACT_EXPIRE, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_EXPIRE, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_MESSAGE, OP_VOTE, '0, '0, '0, '0));
        offer(mk_event(ACT_START, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_MESSAGE, OP_NOMINATION, '1, '1, '1, '1));
        offer(mk_event(ACT_START, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_MESSAGE, OP_LEAD, 32'd6, '0, '0, '0));
        offer(mk_event(ACT_START, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_STOP, OP_NOOP, '0, '0, '0, '0));
        drain();

        // A vote short of a majority re-arms the timer, then the retry limit ends it.
        setting.peer_count = 8'd4;
        setting.min_timeout = 32'd1000;
        setting.max_timeout = 32'd2000;
        setting.retry_limit = 8'd2;
        load_config(setting);
        offer(mk_event(ACT_START, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_MESSAGE, OP_VOTE, '0, '0, '0, '0));
        offer(mk_event(ACT_EXPIRE, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_EXPIRE, OP_NOOP, '0, '0, '0, '0));
        offer(mk_event(ACT_EXPIRE, OP_NOOP, '0, '0, '0, '0));
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_config(phase_setting(phase));
            if (phase == 3)
                hold_requests++;
            if (phase == PHASES - 1)
                quiet = 1'b1;
            if (phase == 1)
            begin
                repeat (2)
                begin
                    offer(mk_event(ACT_START, OP_NOOP, '0, $urandom, '0, '0));
                    repeat (RETRY_RUN) offer(make_event(model_term, model_active, 1'b1));
                end
            end
            else
            begin
                repeat (PHASE_ITEMS) offer(make_event(model_term, model_active, 1'b0));
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
